/* hdl/grid_hazard_dilation_map_assert.svh */
// Assertion macros shared by the grid hazard dilation map RTL.
`ifndef GRID_HAZARD_DILATION_MAP_ASSERT_SVH
`define GRID_HAZARD_DILATION_MAP_ASSERT_SVH
`ifndef SYNTHESIS
// Checked property, quiet while reset is asserted.
`define GHD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property, also active during reset.
`define GHD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GHD_ASSERT(lbl, clk, rst_n, prop, msg)
`define GHD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* hdl/ghd_pkg.sv */
// Types, codes and the neighbor offset table of the grid hazard dilation map.
package ghd_pkg;

  typedef enum logic [0:0] {
    ST_LOAD = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  typedef logic [1:0] level_t;

  localparam level_t LVL_SAFE   = 2'd0;
  localparam level_t LVL_NEAR   = 2'd1;
  localparam level_t LVL_HAZARD = 2'd2;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRATER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK   = 1'b1;

  // Neighbor walk: step 0 is the center, steps 1 to 8 the ring; step 9 closes the cell.
  typedef logic [3:0] step_t;
  localparam step_t STEP_FIRST = 4'd0;
  localparam step_t STEP_CLOSE = 4'd9;

  typedef struct packed {
    logic [1:0] d_row;
    logic [1:0] d_col;
  } offset_t;

  // Two's complement row and column offsets for each step of the walk.
  function automatic offset_t nbr_offset(input step_t step);
    offset_t o;
    case (step)
      4'd1:    o = '{d_row: 2'b11, d_col: 2'b11};
      4'd2:    o = '{d_row: 2'b11, d_col: 2'b00};
      4'd3:    o = '{d_row: 2'b11, d_col: 2'b01};
      4'd4:    o = '{d_row: 2'b00, d_col: 2'b11};
      4'd5:    o = '{d_row: 2'b00, d_col: 2'b01};
      4'd6:    o = '{d_row: 2'b01, d_col: 2'b11};
      4'd7:    o = '{d_row: 2'b01, d_col: 2'b00};
      4'd8:    o = '{d_row: 2'b01, d_col: 2'b01};
      default: o = '{d_row: 2'b00, d_col: 2'b00};
    endcase
    return o;
  endfunction

endpackage

/* hdl/ghd_mask_ram.sv */
// One-bit hazard mask memory with one write port and one registered read port.
module ghd_mask_ram #(
  parameter int unsigned DEPTH = 25,
  parameter int unsigned AW    = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_data
);

  logic mem [DEPTH];
  logic rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/ghd_nbr_unit.sv */
// Neighbor address unit: turns a cell and a walk step into a mask address and an in-grid flag.
module ghd_nbr_unit #(
  parameter int unsigned GRID_SIZE = 5,
  parameter int unsigned AW        = 5
) (
  input  logic [2:0]       row,
  input  logic [2:0]       col,
  input  ghd_pkg::step_t   step,
  output logic             in_grid,
  output logic [AW-1:0]    addr
);

  import ghd_pkg::*;

  offset_t    ofs;
  logic [3:0] nb_row;
  logic [3:0] nb_col;

  // A step off the low edge wraps to a large value and fails the bound check.
  always_comb begin
    ofs     = nbr_offset(step);
    nb_row  = {1'b0, row} + {{2{ofs.d_row[1]}}, ofs.d_row};
    nb_col  = {1'b0, col} + {{2{ofs.d_col[1]}}, ofs.d_col};
    in_grid = (nb_row < 4'(GRID_SIZE)) && (nb_col < 4'(GRID_SIZE));
    addr    = AW'(nb_row[2:0]) * AW'(GRID_SIZE) + AW'(nb_col[2:0]);
  end

endmodule

/* hdl/grid_hazard_dilation_map.sv */
// Top level of the grid hazard dilation map: load, neighbor walk and result register.
//
// The block takes a GRID_SIZE x GRID_SIZE elevation grid in row-major order, one
// signed sample per transfer on the in_ channel. Each sample is compared with the
// crater and peak limits as it arrives and its hazard bit is written to a small
// mask memory. The transfer of the last sample starts the emission of the map.
// During emission the input channel is not ready. For each cell a sequencer walks
// the center and its eight neighbors through one shared address unit and the
// single mask read port, reading only the neighbors that lie inside the grid, and
// then closes the cell in its closing cycle. Each cell's result goes to an output
// register with its row, column, level and, on the last cell, the count of safe
// cells and the last mark.
// If the receiver stalls, the walk holds in its closing cycle until the output
// register frees up; no result is lost or repeated. After the last cell is
// written, the block accepts samples of the next map while that result still waits.
// Limits must be written through the cfg_ port only while the block is idle; the
// block does not enforce this. They apply to samples loaded after the write. Reset
// clears the limits to zero, load count, walk state and output valid, not the mask.
`include "grid_hazard_dilation_map_assert.svh"

module grid_hazard_dilation_map #(
  parameter int unsigned GRID_SIZE = 5
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [15:0]              in_elevation,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_risk_level,
  output logic [2:0]                      out_cell_row,
  output logic [2:0]                      out_cell_col,
  output logic [6:0]                      out_safe_total,
  output logic                            out_last_of_map,
  input  logic                            cfg_wr_en,
  input  logic [ghd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                     cfg_wr_data
);

  import ghd_pkg::*;

  localparam int unsigned CELLS = GRID_SIZE * GRID_SIZE;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);
  localparam logic [2:0]    LAST_IDX  = 3'(GRID_SIZE - 1);

  state_t             state_r, state_nxt;
  logic [AW-1:0]      load_cnt_r, load_cnt_nxt;
  logic [2:0]         row_r, row_nxt;
  logic [2:0]         col_r, col_nxt;
  step_t              step_r, step_nxt;
  logic               center_r, center_nxt;
  logic               near_r, near_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [6:0]         safe_cnt_r, safe_cnt_nxt;
  logic signed [15:0] crater_r, crater_nxt;
  logic signed [15:0] peak_r, peak_nxt;

  logic               out_valid_r, out_valid_nxt;
  level_t             out_level_r, out_level_nxt;
  logic [2:0]         out_row_r, out_row_nxt;
  logic [2:0]         out_col_r, out_col_nxt;
  logic [6:0]         out_safe_r, out_safe_nxt;
  logic               out_last_r, out_last_nxt;

  logic               in_xfer;
  logic               wr_en;
  logic               wr_data;
  logic               rd_en;
  logic               rd_data;
  logic               nb_in_grid;
  logic [AW-1:0]      nb_addr;
  logic               slot_free;
  logic               near_fin;
  level_t             level;
  logic               last_cell;

  ghd_nbr_unit #(
    .GRID_SIZE (GRID_SIZE),
    .AW        (AW)
  ) u_nbr (
    .row     (row_r),
    .col     (col_r),
    .step    (step_r),
    .in_grid (nb_in_grid),
    .addr    (nb_addr)
  );

  ghd_mask_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_mask (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (load_cnt_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (nb_addr),
    .rd_data (rd_data)
  );

  assign in_ready  = (state_r == ST_LOAD);
  assign in_xfer   = in_valid && in_ready;
  assign wr_en     = in_xfer;
  assign wr_data   = (in_elevation < crater_r) || (in_elevation > peak_r);
  assign slot_free = !out_valid_r || out_ready;
  assign last_cell = (row_r == LAST_IDX) && (col_r == LAST_IDX);

  // Reads are issued on steps 0 to 8 and only for neighbors inside the grid.
  assign rd_en = (state_r == ST_SCAN) && (step_r < STEP_CLOSE) && nb_in_grid;

  // The read of the last ring neighbor lands in the closing cycle and is folded in here.
  assign near_fin = near_r || (rd_vld_r && rd_data);

  always_comb begin
    if (center_r) begin
      level = LVL_HAZARD;
    end else if (near_fin) begin
      level = LVL_NEAR;
    end else begin
      level = LVL_SAFE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      load_cnt_r  <= '0;
      row_r       <= '0;
      col_r       <= '0;
      step_r      <= STEP_FIRST;
      safe_cnt_r  <= '0;
      crater_r    <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      step_r      <= step_nxt;
      safe_cnt_r  <= safe_cnt_nxt;
      crater_r    <= crater_nxt;
      peak_r      <= peak_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    center_r    <= center_nxt;
    near_r      <= near_nxt;
    rd_vld_r    <= rd_vld_nxt;
    out_level_r <= out_level_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_safe_r  <= out_safe_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    load_cnt_nxt  = load_cnt_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    step_nxt      = step_r;
    center_nxt    = center_r;
    near_nxt      = near_r;
    rd_vld_nxt    = rd_vld_r;
    safe_cnt_nxt  = safe_cnt_r;
    crater_nxt    = crater_r;
    peak_nxt      = peak_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_level_nxt = out_level_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_safe_nxt  = out_safe_r;
    out_last_nxt  = out_last_r;

    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_CRATER: crater_nxt = signed'(cfg_wr_data);
        CFG_PEAK:   peak_nxt   = signed'(cfg_wr_data);
        default:    ;
      endcase
    end

    case (state_r)
      ST_LOAD: begin
        if (in_xfer) begin
          if (load_cnt_r == LAST_ADDR) begin
            load_cnt_nxt = '0;
            state_nxt    = ST_SCAN;
            row_nxt      = '0;
            col_nxt      = '0;
            step_nxt     = STEP_FIRST;
            safe_cnt_nxt = '0;
          end else begin
            load_cnt_nxt = load_cnt_r + 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (step_r < STEP_CLOSE) begin
          rd_vld_nxt = nb_in_grid;
          step_nxt   = step_r + 1'b1;
        end
        if (step_r == STEP_FIRST) begin
          near_nxt = 1'b0;
        end else if (step_r < STEP_CLOSE) begin
          near_nxt = near_r || (rd_vld_r && rd_data);
          if (step_r == 4'd1) begin
            center_nxt = rd_vld_r && rd_data;
          end
        end else if (slot_free) begin
          // Closing cycle: hand the cell to the output register and move on.
          out_valid_nxt = 1'b1;
          out_level_nxt = level;
          out_row_nxt   = row_r;
          out_col_nxt   = col_r;
          out_last_nxt  = last_cell;
          safe_cnt_nxt  = safe_cnt_r + 7'((level == LVL_SAFE) ? 1 : 0);
          out_safe_nxt  = last_cell ? safe_cnt_nxt : 7'd0;
          step_nxt      = STEP_FIRST;
          if (last_cell) begin
            state_nxt = ST_LOAD;
          end else if (col_r == LAST_IDX) begin
            col_nxt = '0;
            row_nxt = row_r + 1'b1;
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_risk_level  = out_level_r;
  assign out_cell_row    = out_row_r;
  assign out_cell_col    = out_col_r;
  assign out_safe_total  = out_safe_r;
  assign out_last_of_map = out_last_r;

  `GHD_ASSERT(a_last_sample_starts_scan, clk, rst_n, (in_xfer && (load_cnt_r == LAST_ADDR)) |=> (state_r == ST_SCAN), "last sample did not start the scan")
  `GHD_ASSERT(a_safe_total_only_last, clk, rst_n, (out_valid && !out_last_of_map) |-> (out_safe_total == 7'd0), "safe count shown before the last cell")
  `GHD_ASSERT(a_level_code, clk, rst_n, out_valid |-> (out_risk_level != 2'd3), "invalid risk level")
  `GHD_ASSERT(a_cell_in_grid, clk, rst_n, out_valid |-> ((out_cell_row <= LAST_IDX) && (out_cell_col <= LAST_IDX)), "reported cell outside the grid")
  `GHD_ASSERT_ALWAYS(a_step_range, clk, (rst_n && $past(rst_n)) |-> (step_r <= STEP_CLOSE), "walk step out of range")

endmodule
